FILE: sv/gnd_pkg.sv
package gnd_pkg;

    localparam logic [3:0] EV_NONE      = 4'd0;
    localparam logic [3:0] EV_GGA       = 4'd1;
    localparam logic [3:0] EV_RMC       = 4'd2;
    localparam logic [3:0] EV_IGNORED   = 4'd3;
    localparam logic [3:0] EV_TOO_LONG  = 4'd4;
    localparam logic [3:0] EV_TIMEOUT   = 4'd5;
    localparam logic [3:0] EV_RTCM_SKIP = 4'd6;
    localparam logic [3:0] EV_RTCM_BAD  = 4'd7;
    localparam logic [3:0] EV_TAKEN     = 4'd8;
    localparam logic [3:0] EV_NOTHING   = 4'd9;
    localparam logic [3:0] EV_READ      = 4'd10;

    localparam logic [1:0] MODE_BYTE = 2'd0;
    localparam logic [1:0] MODE_TICK = 2'd1;
    localparam logic [1:0] MODE_TAKE = 2'd2;
    localparam logic [1:0] MODE_READ = 2'd3;

    localparam logic CFG_FORWARD = 1'b0;
    localparam logic CFG_TIMEOUT = 1'b1;

    localparam logic [7:0] CH_RTCM = 8'hD3;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_G = 8'h47;
    localparam logic [7:0] CH_N = 8'h4E;
    localparam logic [7:0] CH_P = 8'h50;
    localparam logic [7:0] CH_A = 8'h41;
    localparam logic [7:0] CH_R = 8'h52;
    localparam logic [7:0] CH_M = 8'h4D;
    localparam logic [7:0] CH_C = 8'h43;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [6:0] length;
        logic       slot;
        logic [3:0] event_res;
    } res_t;

endpackage

FILE: sv/gnd_front.sv
module gnd_front #(
    parameter int MAX_LINE = 82,
    parameter int MAX_FRAME = 1023
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  logic [1:0]        mode,
    input  logic [7:0]        rx_byte,
    input  logic              slot_select,
    input  logic [6:0]        byte_index,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [15:0]       cfg_data,
    output logic              out_valid,
    output gnd_pkg::res_t     out_res
);
    localparam int CW = $clog2(MAX_LINE + 1);
    localparam int DEPTH = 3 * MAX_LINE;
    localparam int AW = $clog2(DEPTH);
    localparam int BW = $clog2(MAX_FRAME + 4);

    typedef enum logic [2:0] {
        PH_IDLE, PH_LEN_HI, PH_LEN_LO, PH_SKIP, PH_LINE, PH_DISCARD
    } phase_t;

    phase_t          phase_reg, phase_next;
    logic [7:0]      len_hi_reg, len_hi_next;
    logic [BW-1:0]   left_reg, left_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [15:0]     idle_reg, idle_next;
    logic [7:0]      pf_reg [6];
    logic [7:0]      pf_next [6];
    logic [CW-1:0]   slen_reg [2];
    logic [CW-1:0]   slen_next [2];
    logic [1:0]      pend_reg, pend_next;
    logic [1:0]      bank_reg [2];
    logic [1:0]      bank_next [2];
    logic [1:0]      lbank_reg, lbank_next;
    logic            fwd_reg;
    logic [15:0]     tmo_reg;
    logic            valid_reg;
    gnd_pkg::res_t   res_reg, res_next;
    logic            rdok_reg, rdok_next;
    logic [7:0]      rd_q;
    logic [7:0]      mem [DEPTH];
    logic            wr_en, rd_en;
    logic [CW-1:0]   wr_idx;
    logic [AW-1:0]   wr_addr, rd_addr;
    logic [15:0]     frame_len;
    logic [15:0]     idle_inc;
    logic            is_gga, is_rmc, talker_ok;

    // The line buffer and both slots are three banks of one memory; storing
    // a sentence swaps the line bank with the slot bank instead of copying.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= rx_byte;
        end
        if (rd_en) begin
            rd_q <= mem[rd_addr];
        end
    end

    assign frame_len = {len_hi_reg, rx_byte};
    assign idle_inc = (idle_reg == 16'hFFFF) ? idle_reg : idle_reg + 16'd1;
    assign talker_ok = (pf_reg[0] == gnd_pkg::CH_DOLLAR) && (pf_reg[1] == gnd_pkg::CH_G)
        && ((pf_reg[2] == gnd_pkg::CH_N) || (pf_reg[2] == gnd_pkg::CH_P))
        && (cnt_reg >= CW'(6));
    assign is_gga = talker_ok && (pf_reg[3] == gnd_pkg::CH_G)
        && (pf_reg[4] == gnd_pkg::CH_G) && (pf_reg[5] == gnd_pkg::CH_A);
    assign is_rmc = talker_ok && (pf_reg[3] == gnd_pkg::CH_R)
        && (pf_reg[4] == gnd_pkg::CH_M) && (pf_reg[5] == gnd_pkg::CH_C);
    assign rd_addr = AW'(16'(bank_reg[slot_select]) * 16'(MAX_LINE) + 16'(byte_index));
    assign wr_addr = AW'(16'(lbank_reg) * 16'(MAX_LINE) + 16'(wr_idx));

    always_comb begin
        phase_next = phase_reg;
        len_hi_next = len_hi_reg;
        left_next = left_reg;
        cnt_next = cnt_reg;
        idle_next = idle_reg;
        pf_next = pf_reg;
        slen_next = slen_reg;
        pend_next = pend_reg;
        bank_next = bank_reg;
        lbank_next = lbank_reg;
        res_next = '0;
        rdok_next = 1'b0;
        wr_en = 1'b0;
        wr_idx = cnt_reg;
        rd_en = 1'b0;
        if (in_valid) begin
            case (mode)
                gnd_pkg::MODE_BYTE: begin
                    case (phase_reg)
                        PH_IDLE: begin
                            if (rx_byte == gnd_pkg::CH_RTCM) begin
                                phase_next = PH_LEN_HI;
                            end else if (rx_byte == gnd_pkg::CH_DOLLAR) begin
                                wr_idx = '0;
                                wr_en = 1'b1;
                                pf_next[0] = rx_byte;
                                cnt_next = CW'(1);
                                idle_next = '0;
                                phase_next = PH_LINE;
                            end
                        end
                        PH_LEN_HI: begin
                            len_hi_next = rx_byte;
                            phase_next = PH_LEN_LO;
                        end
                        PH_LEN_LO: begin
                            if (frame_len == 16'd0 || frame_len > 16'(MAX_FRAME)) begin
                                phase_next = PH_IDLE;
                                res_next.event_res = gnd_pkg::EV_RTCM_BAD;
                            end else begin
                                left_next = BW'(frame_len + 16'd3);
                                phase_next = PH_SKIP;
                            end
                        end
                        PH_SKIP: begin
                            left_next = (left_reg != '0) ? left_reg - BW'(1) : left_reg;
                            if (left_next == '0) begin
                                phase_next = PH_IDLE;
                                res_next.event_res = gnd_pkg::EV_RTCM_SKIP;
                            end
                        end
                        PH_LINE: begin
                            if (rx_byte == gnd_pkg::CH_LF) begin
                                phase_next = PH_IDLE;
                                if ((is_gga || is_rmc) && fwd_reg) begin
                                    res_next.event_res = is_gga ? gnd_pkg::EV_GGA
                                                                : gnd_pkg::EV_RMC;
                                    res_next.slot = is_rmc;
                                    res_next.length = 7'(cnt_reg);
                                    slen_next[is_rmc] = cnt_reg;
                                    pend_next[is_rmc] = 1'b1;
                                    bank_next[is_rmc] = lbank_reg;
                                    lbank_next = bank_reg[is_rmc];
                                end else begin
                                    res_next.event_res = gnd_pkg::EV_IGNORED;
                                end
                            end else if (rx_byte != gnd_pkg::CH_CR) begin
                                idle_next = '0;
                                if (cnt_reg >= CW'(MAX_LINE)) begin
                                    phase_next = PH_DISCARD;
                                    res_next.event_res = gnd_pkg::EV_TOO_LONG;
                                end else begin
                                    wr_en = 1'b1;
                                    if (cnt_reg < CW'(6)) begin
                                        pf_next[cnt_reg[2:0]] = rx_byte;
                                    end
                                    cnt_next = cnt_reg + CW'(1);
                                end
                            end
                        end
                        PH_DISCARD: begin
                            if (rx_byte == gnd_pkg::CH_LF) begin
                                phase_next = PH_IDLE;
                            end else begin
                                idle_next = '0;
                            end
                        end
                        default: phase_next = PH_IDLE;
                    endcase
                end
                gnd_pkg::MODE_TICK: begin
                    if (phase_reg == PH_LINE || phase_reg == PH_DISCARD) begin
                        idle_next = idle_inc;
                        if (idle_inc >= tmo_reg) begin
                            idle_next = '0;
                            if (phase_reg == PH_LINE) begin
                                phase_next = PH_DISCARD;
                                res_next.event_res = gnd_pkg::EV_TIMEOUT;
                            end else begin
                                phase_next = PH_IDLE;
                            end
                        end
                    end
                end
                gnd_pkg::MODE_TAKE: begin
                    if (pend_reg[0] || pend_reg[1]) begin
                        res_next.event_res = gnd_pkg::EV_TAKEN;
                        res_next.slot = !pend_reg[0];
                        res_next.length = 7'(slen_reg[!pend_reg[0]]);
                        pend_next[!pend_reg[0]] = 1'b0;
                    end else begin
                        res_next.event_res = gnd_pkg::EV_NOTHING;
                    end
                end
                gnd_pkg::MODE_READ: begin
                    res_next.event_res = gnd_pkg::EV_READ;
                    res_next.slot = slot_select;
                    rdok_next = 8'(byte_index) < 8'(slen_reg[slot_select]);
                    rd_en = rdok_next;
                end
                default: res_next = '0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            len_hi_reg <= '0;
            left_reg <= '0;
            cnt_reg <= '0;
            idle_reg <= '0;
            slen_reg[0] <= '0;
            slen_reg[1] <= '0;
            pend_reg <= '0;
            bank_reg[0] <= 2'd0;
            bank_reg[1] <= 2'd1;
            lbank_reg <= 2'd2;
            fwd_reg <= 1'b1;
            tmo_reg <= 16'd200;
            valid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            len_hi_reg <= len_hi_next;
            left_reg <= left_next;
            cnt_reg <= cnt_next;
            idle_reg <= idle_next;
            slen_reg <= slen_next;
            pend_reg <= pend_next;
            bank_reg <= bank_next;
            lbank_reg <= lbank_next;
            valid_reg <= in_valid;
            if (cfg_we) begin
                if (cfg_index == gnd_pkg::CFG_FORWARD) begin
                    fwd_reg <= cfg_data[0];
                end else begin
                    tmo_reg <= cfg_data;
                end
            end
        end
        pf_reg <= pf_next;
        res_reg <= res_next;
        rdok_reg <= rdok_next;
    end

    assign out_valid = valid_reg;
    always_comb begin
        out_res = res_reg;
        out_res.data_byte = rdok_reg ? rd_q : 8'd0;
    end

    a_banks_distinct: assert property (@(posedge aclk) disable iff (!aresetn)
        (bank_reg[0] != bank_reg[1]) && (bank_reg[0] != lbank_reg)
        && (bank_reg[1] != lbank_reg))
        else $error("slot and line banks overlap");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(MAX_LINE))
        else $error("line count beyond maximum");
    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (slen_reg[0] <= CW'(MAX_LINE)) && (slen_reg[1] <= CW'(MAX_LINE)))
        else $error("slot length beyond maximum");
endmodule

FILE: sv/gnd_queue.sv
module gnd_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  gnd_pkg::res_t push_data,
    input  logic          pop,
    output logic          not_empty,
    output gnd_pkg::res_t head,
    output logic [2:0]    count
);
    gnd_pkg::res_t slots_reg [4];
    logic [1:0]    wp_reg, rp_reg;
    logic [2:0]    cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wp_reg <= wp_reg + 2'd1;
            end
            if (pop) begin
                rp_reg <= rp_reg + 2'd1;
            end
            cnt_reg <= cnt_reg + 3'(push) - 3'(pop);
        end
        if (push) begin
            slots_reg[wp_reg] <= push_data;
        end
    end

    assign not_empty = cnt_reg != 3'd0;
    assign head = slots_reg[rp_reg];
    assign count = cnt_reg;

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (cnt_reg != 3'd4 || pop))
        else $error("queue overflow");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> cnt_reg != 3'd0)
        else $error("queue underflow");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 3'd4)
        else $error("queue count out of range");
endmodule

FILE: sv/gnss_rtcm_nmea_stream_demux_core.sv
// Splits a GNSS receiver byte stream: RTCM3 frames are skipped, NMEA GGA and
// RMC sentences are kept in two slots that can be taken or read byte by byte.
// One beat in (byte, tick, take or read) gives exactly one result beat. The
// block takes one beat per cycle while s_tready is high; each result passes
// through the parser's result register, which also carries the registered
// read of the sentence memory and loads on the accepting edge, then through
// the queue and the output register.
// A four-entry queue decouples the parser from the output, so the input keeps
// flowing while results wait up to that depth.
module gnss_rtcm_nmea_stream_demux_core #(
    parameter int MAX_LINE = 82,
    parameter int MAX_FRAME = 1023
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // mode[1:0], rx_byte[9:2], slot_select[10], byte_index[17:11]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // event_res[3:0], slot[4], length[11:5], data_byte[19:12]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);
    logic          front_valid;
    gnd_pkg::res_t front_res;
    logic          q_not_empty, q_pop;
    gnd_pkg::res_t q_head;
    logic [2:0]    q_count;
    logic          m_valid_reg;
    gnd_pkg::res_t m_res_reg;

    // Room is counted for the beat still inside the front pipeline.
    assign s_tready = (4'(q_count) + 4'(front_valid)) < 4'd4;
    assign cfg_ready = 1'b1;

    gnd_front #(.MAX_LINE(MAX_LINE), .MAX_FRAME(MAX_FRAME)) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid && s_tready),
        .mode        (s_tdata[1:0]),
        .rx_byte     (s_tdata[9:2]),
        .slot_select (s_tdata[10]),
        .byte_index  (s_tdata[17:11]),
        .cfg_we      (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_valid   (front_valid),
        .out_res     (front_res)
    );

    gnd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (front_valid),
        .push_data (front_res),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head),
        .count     (q_count)
    );

    assign q_pop = q_not_empty && (!m_valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_tready) begin
            m_valid_reg <= q_not_empty;
        end
        if (q_pop) begin
            m_res_reg <= q_head;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata = {4'd0, m_res_reg};
endmodule
